[src/kmm_pkg.sv]
package kmm_pkg;

  typedef enum logic [3:0] {
    KIND_NOTE          = 4'd0,
    KIND_NOOP          = 4'd1,
    KIND_EXIT          = 4'd2,
    KIND_PANIC         = 4'd3,
    KIND_SHIFT_UP_OCT  = 4'd4,
    KIND_SHIFT_DN_OCT  = 4'd5,
    KIND_STAY_UP_OCT   = 4'd6,
    KIND_STAY_DN_OCT   = 4'd7,
    KIND_SHIFT_UP_NOTE = 4'd8,
    KIND_SHIFT_DN_NOTE = 4'd9,
    KIND_STAY_UP_NOTE  = 4'd10,
    KIND_STAY_DN_NOTE  = 4'd11
  } action_kind_e;

  typedef enum logic [1:0] {
    MSG_NOTE_ON     = 2'd0,
    MSG_NOTE_OFF    = 2'd1,
    MSG_PANIC_SWEEP = 2'd2,
    MSG_EXIT        = 2'd3
  } msg_kind_e;

  typedef enum logic {
    OP_KEY_EVENT = 1'b0,
    OP_MAP_WRITE = 1'b1
  } operation_e;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 7;

  localparam logic [CfgIdxW-1:0] CFG_MIDI_CHANNEL  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_NOTE_VELOCITY = 1'b1;

  localparam logic [7:0]        STATUS_ON      = 8'h90;
  localparam logic [7:0]        STATUS_OFF     = 8'h80;
  localparam logic signed [4:0] OCTAVE_STEP    = 5'sd12;
  localparam logic signed [4:0] NOTE_STEP      = 5'sd1;
  localparam logic [6:0]        NOTE_MAX       = 7'd127;
  localparam logic [6:0]        SWEEP_TOP      = 7'd126;
  localparam logic [6:0]        VELOCITY_RESET = 7'd64;
  localparam logic [6:0]        EXIT_KEY       = 7'd1;

  typedef struct packed {
    logic [3:0] kind;
    logic [6:0] note;
  } map_entry_t;

  localparam map_entry_t ENTRY_NOOP = '{kind: KIND_NOOP, note: 7'd0};
  localparam map_entry_t ENTRY_EXIT = '{kind: KIND_EXIT, note: 7'd0};

  typedef struct packed {
    logic       en;
    logic [6:0] key_code;
  } map_rd_t;

  typedef struct packed {
    logic       en;
    logic [6:0] key_code;
    map_entry_t entry;
  } map_wr_t;

  typedef struct packed {
    logic       operation;
    logic [6:0] key_code;
    logic       key_down;
    logic [3:0] action_kind;
    logic [6:0] map_note;
  } key_item_t;

  typedef struct packed {
    msg_kind_e  message_kind;
    logic [7:0] status_byte;
    logic [6:0] pitch;
    logic [6:0] velocity_out;
  } msg_t;

endpackage

[src/kmm_ifs.sv]
interface kmm_key_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [6:0] key_code;
  logic       key_down;
  logic [3:0] action_kind;
  logic [6:0] map_note;

  modport source (
    output valid, operation, key_code, key_down, action_kind, map_note,
    input  ready
  );
  modport sink (
    input  valid, operation, key_code, key_down, action_kind, map_note,
    output ready
  );
endinterface

interface kmm_msg_if;
  logic       valid;
  logic       ready;
  logic [1:0] message_kind;
  logic [7:0] status_byte;
  logic [6:0] pitch;
  logic [6:0] velocity_out;

  modport source (
    output valid, message_kind, status_byte, pitch, velocity_out,
    input  ready
  );
  modport sink (
    input  valid, message_kind, status_byte, pitch, velocity_out,
    output ready
  );
endinterface

[src/key_event_to_midi_note_mapper_top.sv]
// Path: an accepted item is registered with its key map read, and its result is then held in the output register.
// Throughput: one item per cycle, set by the single registered pass through the
// key map read and the event logic; the input stalls only while the result register
// is held and the event stage also carries a result.
// Reset: key map reads as noop with key 1 as exit, no keys held, transposition
// zero, not halted, channel 0, velocity 64; no clearing pass is needed.
module key_event_to_midi_note_mapper_top
  import kmm_pkg::*;
#(
  parameter int unsigned KEY_COUNT = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  kmm_key_if.sink             key_i,
  kmm_msg_if.source           msg_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic       s1_vld_q;
  key_item_t  s1_item_q;
  logic       out_vld_q;
  msg_t       out_msg_q;
  logic [3:0] midi_channel_q;
  logic [6:0] note_velocity_q;
  logic       accept;
  logic       s1_adv;
  logic       s1_has_res;
  msg_t       s1_msg;
  map_entry_t s1_entry;
  map_rd_t    map_rd;
  map_wr_t    map_wr;

  assign s1_adv      = !s1_vld_q || !s1_has_res || !out_vld_q || msg_o.ready;
  assign key_i.ready = s1_adv;
  assign accept      = key_i.valid && s1_adv;

  assign map_rd.en       = accept;
  assign map_rd.key_code = key_i.key_code;

  kmm_key_map #(.KEY_COUNT(KEY_COUNT)) u_key_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_i    (map_rd),
    .wr_i    (map_wr),
    .entry_o (s1_entry)
  );

  kmm_event_unit #(.KEY_COUNT(KEY_COUNT)) u_event_unit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_vld_i      (s1_vld_q),
    .commit_i        (s1_vld_q && s1_adv),
    .item_i          (s1_item_q),
    .entry_i         (s1_entry),
    .midi_channel_i  (midi_channel_q),
    .note_velocity_i (note_velocity_q),
    .map_wr_o        (map_wr),
    .has_result_o    (s1_has_res),
    .msg_o           (s1_msg)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= '{operation: key_i.operation, key_code: key_i.key_code,
                     key_down: key_i.key_down, action_kind: key_i.action_kind,
                     map_note: key_i.map_note};
    end
    if (s1_vld_q && s1_has_res && s1_adv) begin
      out_msg_q <= s1_msg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q        <= 1'b0;
      out_vld_q       <= 1'b0;
      midi_channel_q  <= 4'd0;
      note_velocity_q <= VELOCITY_RESET;
    end else begin
      if (s1_adv) begin
        s1_vld_q <= accept;
      end
      if (s1_vld_q && s1_has_res && s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (msg_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIDI_CHANNEL:  midi_channel_q  <= cfg_data_i[3:0];
          CFG_NOTE_VELOCITY: note_velocity_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end
    end
  end

  assign msg_o.valid        = out_vld_q;
  assign msg_o.message_kind = out_msg_q.message_kind;
  assign msg_o.status_byte  = out_msg_q.status_byte;
  assign msg_o.pitch        = out_msg_q.pitch;
  assign msg_o.velocity_out = out_msg_q.velocity_out;

endmodule

[src/kmm_key_map.sv]
module kmm_key_map
  import kmm_pkg::*;
#(
  parameter int unsigned KEY_COUNT = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  map_rd_t    rd_i,
  input  map_wr_t    wr_i,
  output map_entry_t entry_o
);

  localparam int unsigned IdxW = $clog2(KEY_COUNT);

  map_entry_t           mem_q [KEY_COUNT];
  logic [KEY_COUNT-1:0] vld_q;
  map_entry_t           rd_q;
  map_entry_t           fwd_entry_q;
  logic                 fwd_q;
  logic [6:0]           rd_code_q;
  logic [IdxW-1:0]      wr_idx;
  logic [IdxW-1:0]      rd_idx;
  logic [IdxW-1:0]      rd_idx_q;

  assign wr_idx   = IdxW'(wr_i.key_code);
  assign rd_idx   = IdxW'(rd_i.key_code);
  assign rd_idx_q = IdxW'(rd_code_q);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_idx] <= wr_i.entry;
    end
    if (rd_i.en) begin
      rd_q        <= mem_q[rd_idx];
      fwd_entry_q <= wr_i.entry;
      rd_code_q   <= rd_i.key_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      fwd_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_idx] <= 1'b1;
      end
      if (rd_i.en) begin
        fwd_q <= wr_i.en && (wr_i.key_code == rd_i.key_code);
      end
    end
  end

  // A write that commits on the read edge is forwarded; unwritten entries
  // read as their reset contents.
  always_comb begin
    if (fwd_q) begin
      entry_o = fwd_entry_q;
    end else if (vld_q[rd_idx_q]) begin
      entry_o = rd_q;
    end else if (rd_code_q == EXIT_KEY) begin
      entry_o = ENTRY_EXIT;
    end else begin
      entry_o = ENTRY_NOOP;
    end
  end

endmodule

[src/kmm_event_unit.sv]
module kmm_event_unit
  import kmm_pkg::*;
#(
  parameter int unsigned KEY_COUNT = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_vld_i,
  input  logic       commit_i,
  input  key_item_t  item_i,
  input  map_entry_t entry_i,
  input  logic [3:0] midi_channel_i,
  input  logic [6:0] note_velocity_i,
  output map_wr_t    map_wr_o,
  output logic       has_result_o,
  output msg_t       msg_o
);

  localparam int unsigned IdxW = $clog2(KEY_COUNT);

  logic [KEY_COUNT-1:0] held_q;
  logic signed [7:0]    transpose_q;
  logic signed [7:0]    transpose_d;
  logic                 halted_q;
  logic                 halted_d;
  logic                 act;
  logic                 code_ok;
  logic                 is_press;
  logic                 is_release;
  logic                 held;
  logic signed [4:0]    delta;
  logic signed [8:0]    tsum;
  logic signed [8:0]    psum;
  logic [6:0]           pitch;
  logic [IdxW-1:0]      idx;
  logic [3:0]           status_ch;

  assign idx        = IdxW'(item_i.key_code);
  assign code_ok    = 32'(item_i.key_code) < KEY_COUNT;
  assign act        = item_vld_i && !halted_q && code_ok;
  assign held       = held_q[idx];
  assign is_press   = act && (item_i.operation == OP_KEY_EVENT) && item_i.key_down && !held;
  assign is_release = act && (item_i.operation == OP_KEY_EVENT) && !item_i.key_down;
  assign status_ch  = midi_channel_i;

  assign map_wr_o.en       = commit_i && act && (item_i.operation == OP_MAP_WRITE);
  assign map_wr_o.key_code = item_i.key_code;
  assign map_wr_o.entry    = '{kind: item_i.action_kind, note: item_i.map_note};

  assign psum = $signed({2'b00, entry_i.note}) + $signed({transpose_q[7], transpose_q});

  always_comb begin
    if (psum[8]) begin
      pitch = 7'd0;
    end else if (psum[7]) begin
      pitch = NOTE_MAX;
    end else begin
      pitch = psum[6:0];
    end
  end

  always_comb begin
    delta        = 5'sd0;
    halted_d     = halted_q;
    has_result_o = 1'b0;
    msg_o        = '{message_kind: MSG_NOTE_ON, status_byte: 8'd0, pitch: 7'd0,
                     velocity_out: 7'd0};
    if (is_press) begin
      case (entry_i.kind)
        KIND_NOTE: begin
          has_result_o = 1'b1;
          msg_o = '{message_kind: MSG_NOTE_ON, status_byte: STATUS_ON | {4'd0, status_ch},
                    pitch: pitch, velocity_out: note_velocity_i};
        end
        KIND_EXIT: begin
          has_result_o = 1'b1;
          halted_d     = 1'b1;
          msg_o.message_kind = MSG_EXIT;
        end
        KIND_PANIC: begin
          has_result_o = 1'b1;
          msg_o = '{message_kind: MSG_PANIC_SWEEP,
                    status_byte: STATUS_OFF | {4'd0, status_ch},
                    pitch: SWEEP_TOP, velocity_out: 7'd0};
        end
        KIND_SHIFT_UP_OCT, KIND_STAY_UP_OCT:   delta = OCTAVE_STEP;
        KIND_SHIFT_DN_OCT, KIND_STAY_DN_OCT:   delta = -OCTAVE_STEP;
        KIND_SHIFT_UP_NOTE, KIND_STAY_UP_NOTE: delta = NOTE_STEP;
        KIND_SHIFT_DN_NOTE, KIND_STAY_DN_NOTE: delta = -NOTE_STEP;
        default: delta = 5'sd0;
      endcase
    end else if (is_release) begin
      case (entry_i.kind)
        KIND_NOTE: begin
          has_result_o = 1'b1;
          msg_o = '{message_kind: MSG_NOTE_OFF, status_byte: STATUS_OFF | {4'd0, status_ch},
                    pitch: pitch, velocity_out: 7'd0};
        end
        KIND_SHIFT_UP_OCT:  delta = -OCTAVE_STEP;
        KIND_SHIFT_DN_OCT:  delta = OCTAVE_STEP;
        KIND_SHIFT_UP_NOTE: delta = -NOTE_STEP;
        KIND_SHIFT_DN_NOTE: delta = NOTE_STEP;
        default: delta = 5'sd0;
      endcase
    end
  end

  assign tsum = $signed({transpose_q[7], transpose_q}) + $signed({{4{delta[4]}}, delta});

  always_comb begin
    if (tsum[8] != tsum[7]) begin
      transpose_d = tsum[8] ? -8'sd128 : 8'sd127;
    end else begin
      transpose_d = tsum[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      transpose_q <= 8'sd0;
      halted_q    <= 1'b0;
    end else if (commit_i) begin
      transpose_q <= transpose_d;
      halted_q    <= halted_d;
      if (is_press) begin
        held_q[idx] <= 1'b1;
      end else if (is_release) begin
        held_q[idx] <= 1'b0;
      end
    end
  end

endmodule

[src/kmm_checker.sv]
module kmm_checker
  import kmm_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] message_kind_i,
  input logic [7:0] status_byte_i,
  input logic [6:0] pitch_i,
  input logic [6:0] velocity_out_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Result item dropped while stalled.");

  a_exit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && (message_kind_i == MSG_EXIT) |=> !out_valid_i)
    else $error("Result item after exit.");

  a_exit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (message_kind_i == MSG_EXIT) |->
      (status_byte_i == 8'd0) && (pitch_i == 7'd0) && (velocity_out_i == 7'd0))
    else $error("Exit item carries nonzero fields.");

  a_off_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((message_kind_i == MSG_NOTE_OFF) || (message_kind_i == MSG_PANIC_SWEEP))
      |-> (velocity_out_i == 7'd0) && (status_byte_i[7:4] == STATUS_OFF[7:4]))
    else $error("Note-off item has wrong status or velocity.");

  a_panic_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (message_kind_i == MSG_PANIC_SWEEP) |-> (pitch_i == SWEEP_TOP))
    else $error("Panic item has wrong sweep top.");

endmodule

bind key_event_to_midi_note_mapper_top kmm_checker u_kmm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (msg_o.valid),
  .out_ready_i    (msg_o.ready),
  .message_kind_i (msg_o.message_kind),
  .status_byte_i  (msg_o.status_byte),
  .pitch_i        (msg_o.pitch),
  .velocity_out_i (msg_o.velocity_out)
);
